/* design/tvmf_pkg.sv */
// Shared types, constants and helpers for the TSDF voxel multi-source fusion block.
// Used by tvmf_fuse_unit and tsdf_voxel_multi_fusion; depends on nothing.
package tvmf_pkg;

   localparam int NumSourcesDefault = 5;
   localparam int MaxSources        = 5;
   localparam int TsdfFull          = 32766;
   localparam logic [14:0] MaxWeightReset = 15'd100;
   // quotient magnitude never exceeds 32768, so 16 quotient bits suffice
   localparam int QuotBits     = 16;
   localparam int BitsPerStage = 2;
   localparam int DivStages    = QuotBits / BitsPerStage;

   typedef struct packed {
      logic signed [15:0] stored_tsdf;
      logic [14:0]        stored_weight;
      logic signed [15:0] sample_0;
      logic signed [15:0] sample_1;
      logic signed [15:0] sample_2;
      logic signed [15:0] sample_3;
      logic signed [15:0] sample_4;
      logic [4:0]         sample_valid;
   } req_type;

   typedef struct packed {
      logic signed [15:0] fused_tsdf;
      logic [14:0]        fused_weight;
      logic               write_enable;
   } rsp_type;

   // running voxel state plus the item it came from
   typedef struct packed {
      logic signed [15:0] t;
      logic [14:0]        w;
      req_type            req;
   } lane_type;

   // one slot of the divider pipeline
   typedef struct packed {
      logic               vld;
      logic               act;
      logic               neg;
      logic [15:0]        d;
      logic [30:0]        rem;
      logic [QuotBits-1:0] q;
      lane_type           lane;
   } div_type;

   function automatic logic signed [15:0] pick_sample(req_type r, int idx);
      logic signed [15:0] s;
      case (idx)
         0:       s = r.sample_0;
         1:       s = r.sample_1;
         2:       s = r.sample_2;
         3:       s = r.sample_3;
         default: s = r.sample_4;
      endcase
      return s;
   endfunction

   // saturate a 17-bit signed value to +/- full scale
   function automatic logic signed [15:0] clamp_full(logic signed [16:0] v);
      logic signed [15:0] r;
      if (v > 17'sd32766)       r = 16'sd32766;
      else if (v < -17'sd32766) r = -16'sd32766;
      else                      r = v[15:0];
      return r;
   endfunction

endpackage

/* design/tvmf_fuse_unit.sv */
// One fusion step: t' = trunc((w*t + s)/(w+1)) clamped, w' = min(w+1, max_weight).
// Multiply, add, eight two-bit divider stages, finish; depends on tvmf_pkg.
module tvmf_fuse_unit #(
   parameter int IDX = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic [14:0]       max_weight,
   input  logic              in_vld,
   input  tvmf_pkg::lane_type in_lane,
   output logic              out_vld,
   output tvmf_pkg::lane_type out_lane
);

   // stage A: product
   logic                     a_vld_ff;
   logic                     a_act_ff;
   logic signed [31:0]       a_prod_ff;
   tvmf_pkg::lane_type       a_lane_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else if (en) begin
         a_vld_ff <= in_vld;
      end
      if (en) begin
         a_act_ff  <= in_lane.req.sample_valid[IDX];
         a_prod_ff <= $signed({1'b0, in_lane.w}) * in_lane.t;
         a_lane_ff <= in_lane;
      end
   end

   // stage B: add sample, split sign and magnitude
   logic signed [32:0]       b_num;
   logic [32:0]              b_mag;
   tvmf_pkg::div_type        dv_ff [0:tvmf_pkg::DivStages];

   always_comb begin
      b_num = {a_prod_ff[31], a_prod_ff}
            + 33'($signed(tvmf_pkg::pick_sample(a_lane_ff.req, IDX)));
      b_mag = b_num[32] ? 33'(-b_num) : b_num;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff[0].vld <= 1'b0;
      end else if (en) begin
         dv_ff[0].vld <= a_vld_ff;
      end
      if (en) begin
         dv_ff[0].act  <= a_act_ff;
         dv_ff[0].neg  <= b_num[32];
         dv_ff[0].d    <= {1'b0, a_lane_ff.w} + 16'd1;
         dv_ff[0].rem  <= b_mag[30:0];
         dv_ff[0].q    <= '0;
         dv_ff[0].lane <= a_lane_ff;
      end
   end

   // divider stages: two quotient bits each, most significant first
   for (genvar j = 0; j < tvmf_pkg::DivStages; j++) begin : g_div
      tvmf_pkg::div_type nx_in;
      always_comb begin
         logic [31:0] rm;
         logic [31:0] ds;
         logic [3:0]  k;
         nx_in = dv_ff[j];
         rm    = {1'b0, dv_ff[j].rem};
         for (int b = 0; b < tvmf_pkg::BitsPerStage; b++) begin
            k  = 4'(tvmf_pkg::QuotBits - 1 - j * tvmf_pkg::BitsPerStage - b);
            ds = {16'd0, dv_ff[j].d} << k;
            if (rm >= ds) begin
               rm         = rm - ds;
               nx_in.q[k] = 1'b1;
            end
         end
         nx_in.rem = rm[30:0];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[j+1].vld <= 1'b0;
         end else if (en) begin
            dv_ff[j+1].vld <= nx_in.vld;
         end
         if (en) begin
            dv_ff[j+1].act  <= nx_in.act;
            dv_ff[j+1].neg  <= nx_in.neg;
            dv_ff[j+1].d    <= nx_in.d;
            dv_ff[j+1].rem  <= nx_in.rem;
            dv_ff[j+1].q    <= nx_in.q;
            dv_ff[j+1].lane <= nx_in.lane;
         end
      end
   end

   // finish: sign, clamp, weight update; skip when the sample is not valid
   tvmf_pkg::div_type        fin;
   logic signed [16:0]       fin_q;
   logic [15:0]              fin_nw;
   logic                     out_vld_ff;
   tvmf_pkg::lane_type       out_lane_ff;
   tvmf_pkg::lane_type       out_lane_in;

   always_comb begin
      fin    = dv_ff[tvmf_pkg::DivStages];
      fin_q  = fin.neg ? -$signed({1'b0, fin.q}) : $signed({1'b0, fin.q});
      fin_nw = fin.d;
      out_lane_in = fin.lane;
      if (fin.act) begin
         out_lane_in.t = tvmf_pkg::clamp_full(fin_q);
         out_lane_in.w = (fin_nw < {1'b0, max_weight}) ? fin_nw[14:0] : max_weight;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (en) begin
         out_vld_ff <= fin.vld;
      end
      if (en) begin
         out_lane_ff <= out_lane_in;
      end
   end

   assign out_vld  = out_vld_ff;
   assign out_lane = out_lane_ff;

endmodule

/* design/tsdf_voxel_multi_fusion.sv */
// TSDF voxel fusion of up to NUM_SOURCES samples per voxel, fully pipelined.
// Top level; depends on tvmf_pkg and tvmf_fuse_unit.
//
// Accepts one voxel beat per clock and returns one result beat per voxel, in
// order. Each source is fused by its own pipelined unit of 11 register stages
// (product, add, eight two-bit divider stages, finish); the units are chained
// one after another and followed by the output register. The whole pipeline
// advances whenever the output register is empty or being taken; a stall on
// rsp_ready holds every stage. The max_weight register is written through
// the csr_ channel, which is always ready, and resets to 100.
module tsdf_voxel_multi_fusion #(
   parameter int NUM_SOURCES = tvmf_pkg::NumSourcesDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  tvmf_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tvmf_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [14:0]       csr_data
);

   logic               en;
   logic [14:0]        max_weight_ff;
   logic               vld [0:NUM_SOURCES];
   tvmf_pkg::lane_type lane [0:NUM_SOURCES];
   logic               rsp_valid_ff;
   tvmf_pkg::rsp_type  rsp_data_ff;
   tvmf_pkg::rsp_type  rsp_data_in;

   // advance the pipeline when the output slot is free or draining
   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;
   assign csr_ready = 1'b1;

   // hold the weight cap
   always_ff @(posedge clock) begin
      if (reset) begin
         max_weight_ff <= tvmf_pkg::MaxWeightReset;
      end else if (csr_valid) begin
         max_weight_ff <= csr_data;
      end
   end

   // seed the running state from the stored voxel
   always_comb begin
      vld[0]      = req_valid;
      lane[0].t   = req_data.stored_tsdf;
      lane[0].w   = req_data.stored_weight;
      lane[0].req = req_data;
   end

   // chain one fusion unit per source
   for (genvar i = 0; i < NUM_SOURCES; i++) begin : g_src
      tvmf_fuse_unit #(.IDX(i)) u_fuse (
         .clock      (clock),
         .reset      (reset),
         .en         (en),
         .max_weight (max_weight_ff),
         .in_vld     (vld[i]),
         .in_lane    (lane[i]),
         .out_vld    (vld[i+1]),
         .out_lane   (lane[i+1])
      );
   end

   // final clamp and write enable
   always_comb begin
      rsp_data_in.fused_tsdf   = tvmf_pkg::clamp_full(17'($signed(lane[NUM_SOURCES].t)));
      rsp_data_in.fused_weight = lane[NUM_SOURCES].w;
      rsp_data_in.write_enable = (NUM_SOURCES != 1)
                               || lane[NUM_SOURCES].req.sample_valid[0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= vld[NUM_SOURCES];
      end
      if (en) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
